// ===== rtl/wpe_pkg.sv =====
package wpe_pkg;

   typedef logic [7:0] byte_type;

   localparam int MarkLen   = 5;
   localparam int OwnerLen  = 8;
   localparam int MaskLen   = 9;
   localparam int WinLen    = MarkLen + 1 + OwnerLen;
   // Window positions that can hold a marker start with its mark byte inside
   // the window: 0 through WinLen - (MarkLen + 1).
   localparam int NumStarts = WinLen - MarkLen;
   // Positions read by a check at the highest start, past-the-end reads zero.
   localparam int ExtLen    = NumStarts - 1 + WinLen;
   localparam int SelBits   = $clog2(NumStarts);
   localparam int ExtBits   = $clog2(ExtLen);

   localparam byte_type MARKER [MarkLen] = '{8'h32, 8'h24, 8'h31, 8'h20, 8'h37};
   localparam byte_type OWNER_MASK [MaskLen] =
      '{8'hAA, 8'h45, 8'hFE, 8'hDD, 8'hE0, 8'h77, 8'h17, 8'h21, 8'hC0};

endpackage

// ===== rtl/watermark_pattern_extractor.sv =====
// Channel  Direction  Words                                    Handshake
// req      in         data_byte, end_of_stream                 req_valid / req_ready
// rsp      out        match_offset, mark_number, owner_0..7,    rsp_valid / rsp_ready
//                     final_record
//
// A word is taken in any cycle the check register is free; its 14-byte window
// snapshot lands there and the result register loads from it on the next edge if it holds a marker
// and the rsp side is free. Throughput is one word per clock while the rsp side takes results;
// only a last word whose flush finds two markers holds the check register until both have moved on.
// Synchronous active-high reset clears the window, the byte offset and all valid flags.
// A stalled rsp side holds the result register; req_ready drops once the check register waits too.
module watermark_pattern_extractor #(
   parameter int OFFSET_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [31:0] rsp_match_offset,
   output logic [7:0] rsp_mark_number,
   output logic [7:0] rsp_owner_0,
   output logic [7:0] rsp_owner_1,
   output logic [7:0] rsp_owner_2,
   output logic [7:0] rsp_owner_3,
   output logic [7:0] rsp_owner_4,
   output logic [7:0] rsp_owner_5,
   output logic [7:0] rsp_owner_6,
   output logic [7:0] rsp_owner_7,
   output logic       rsp_final_record
);

   localparam int WinLen    = wpe_pkg::WinLen;
   localparam int NumStarts = wpe_pkg::NumStarts;
   localparam int ExtLen    = wpe_pkg::ExtLen;
   localparam int MarkLen   = wpe_pkg::MarkLen;
   localparam int OwnerLen  = wpe_pkg::OwnerLen;
   localparam int MaskLen   = wpe_pkg::MaskLen;
   localparam int SelBits   = wpe_pkg::SelBits;
   localparam int ExtBits   = wpe_pkg::ExtBits;

   // Running stream state: the sliding window (element 0 is the oldest byte)
   // and the count of bytes taken so far in this stream.
   wpe_pkg::byte_type win_ff [WinLen];
   wpe_pkg::byte_type win_in [WinLen];
   wpe_pkg::byte_type shift_win [WinLen];
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [OFFSET_BITS-1:0] first_start;

   // Check register: a snapshot of the window as it stood after one word.
   logic                   chk_valid_ff, chk_valid_in;
   wpe_pkg::byte_type      chk_win_ff [WinLen];
   logic [OFFSET_BITS-1:0] chk_start_ff;
   logic                   chk_last_ff;
   logic [NumStarts-1:0]   chk_sent_ff, chk_sent_in;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_offset_ff;
   wpe_pkg::byte_type      rsp_mark_ff;
   wpe_pkg::byte_type      rsp_owner_ff [OwnerLen];
   logic                   rsp_final_ff;

   wpe_pkg::byte_type      ext [ExtLen];
   logic [NumStarts-1:0]   hit, remain, pick;
   logic [SelBits-1:0]     sel;
   logic                   more;
   logic                   out_load;
   logic                   chk_free;
   logic                   req_accept;
   logic [OFFSET_BITS-1:0] match_start;
   wpe_pkg::byte_type      mark_sel;
   wpe_pkg::byte_type      owner_sel [OwnerLen];

   // Window after shifting in the new byte, and the offset of its oldest slot.
   always_comb begin
      for (int i = 0; i < WinLen - 1; i++) begin
         shift_win[i] = win_ff[i+1];
      end
      shift_win[WinLen-1] = req_data_byte;
      first_start = offset_ff - OFFSET_BITS'(WinLen - 1);
   end

   // Marker checks over the snapshot. Bytes past the end of the window read
   // as zero, which is what the flush on the last word of a stream needs.
   always_comb begin
      for (int i = 0; i < WinLen; i++) begin
         ext[i] = chk_win_ff[i];
      end
      for (int i = WinLen; i < ExtLen; i++) begin
         ext[i] = '0;
      end
      for (int k = 0; k < NumStarts; k++) begin
         hit[k] = 1'b1;
         for (int j = 0; j < MarkLen; j++) begin
            if (ext[k+j] != wpe_pkg::MARKER[j]) begin
               hit[k] = 1'b0;
            end
         end
      end
      // Only the oldest start is complete on an ordinary word; the other
      // starts are looked at only when the stream ends.
      if (!chk_last_ff) begin
         hit[NumStarts-1:1] = '0;
      end
   end

   // Pick the lowest start not yet handed on; results leave in rising offset.
   always_comb begin
      remain = chk_valid_ff ? (hit & ~chk_sent_ff) : '0;
      pick   = remain & (~remain + NumStarts'(1));
      more   = (remain & ~pick) != '0;
      sel    = '0;
      for (int k = NumStarts - 1; k >= 0; k--) begin
         if (remain[k]) begin
            sel = SelBits'(k);
         end
      end
      match_start = chk_start_ff + OFFSET_BITS'(sel);
      mark_sel    = ext[ExtBits'(sel) + ExtBits'(MarkLen)];
      for (int j = 0; j < OwnerLen; j++) begin
         owner_sel[j] = ext[ExtBits'(sel) + ExtBits'(MarkLen + 1 + j)]
                        ^ wpe_pkg::OWNER_MASK[j % MaskLen];
      end
   end

   // Handshake and next-state logic.
   always_comb begin
      out_load   = (remain != '0) && (!rsp_valid_ff || rsp_ready);
      // The check register frees up once its last pending result moves on.
      chk_free   = !chk_valid_ff || (remain == '0) || (out_load && !more);
      req_ready  = chk_free;
      req_accept = req_valid && req_ready;

      win_in    = win_ff;
      offset_in = offset_ff;
      if (req_accept) begin
         if (req_end_of_stream) begin
            for (int i = 0; i < WinLen; i++) begin
               win_in[i] = '0;
            end
            offset_in = '0;
         end else begin
            win_in    = shift_win;
            offset_in = offset_ff + OFFSET_BITS'(1);
         end
      end

      if (req_accept) begin
         chk_valid_in = 1'b1;
      end else if (chk_free) begin
         chk_valid_in = 1'b0;
      end else begin
         chk_valid_in = chk_valid_ff;
      end

      if (chk_free) begin
         chk_sent_in = '0;
      end else if (out_load) begin
         chk_sent_in = chk_sent_ff | pick;
      end else begin
         chk_sent_in = chk_sent_ff;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WinLen; i++) begin
            win_ff[i] <= '0;
         end
         offset_ff    <= '0;
         chk_valid_ff <= 1'b0;
         chk_sent_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         offset_ff    <= offset_in;
         chk_valid_ff <= chk_valid_in;
         chk_sent_ff  <= chk_sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         chk_win_ff   <= shift_win;
         chk_start_ff <= first_start;
         chk_last_ff  <= req_end_of_stream;
      end
      if (out_load) begin
         rsp_offset_ff <= 32'(match_start);
         rsp_mark_ff   <= mark_sel;
         rsp_owner_ff  <= owner_sel;
         rsp_final_ff  <= !more;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_offset = rsp_offset_ff;
   assign rsp_mark_number  = rsp_mark_ff;
   assign rsp_owner_0      = rsp_owner_ff[0];
   assign rsp_owner_1      = rsp_owner_ff[1];
   assign rsp_owner_2      = rsp_owner_ff[2];
   assign rsp_owner_3      = rsp_owner_ff[3];
   assign rsp_owner_4      = rsp_owner_ff[4];
   assign rsp_owner_5      = rsp_owner_ff[5];
   assign rsp_owner_6      = rsp_owner_ff[6];
   assign rsp_owner_7      = rsp_owner_ff[7];
   assign rsp_final_record = rsp_final_ff;

endmodule

// ===== rtl/wpe_checker.sv =====
module wpe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_match_offset,
   input logic        rsp_final_record
);

   // A stalled result word stays valid and keeps its offset.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_offset))
      else $error("result word changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The second record of a word is ready as soon as the first one leaves.
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_record |=> rsp_valid)
      else $error("gap after a non-final record");

   // A word never causes more than two records.
   a_two_at_most: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_record |=> rsp_final_record)
      else $error("more than two records for one word");

endmodule

bind watermark_pattern_extractor wpe_checker u_wpe_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_match_offset(rsp_match_offset),
   .rsp_final_record(rsp_final_record)
);
